// ===== hw/rtl/mcsw_pkg.sv =====
package mcsw_pkg;

    localparam int MAX_CHIPS = 12;
    localparam int IDX_W     = (MAX_CHIPS > 1) ? $clog2(MAX_CHIPS) : 1;

    localparam logic [3:0]  CHIPS_IN_USE_RST   = 4'd1;
    localparam logic [2:0]  MISS_LIMIT_RST     = 3'd5;
    localparam logic [31:0] WRAP_LIMIT_RST     = 32'd5000000;
    localparam logic [15:0] GIVEUP_LIMIT_RST   = 16'd50;
    localparam logic        RESTART_ENABLE_RST = 1'b0;

    localparam logic [2:0]  MISS_MAX  = 3'd7;
    localparam logic [15:0] TOTAL_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        CFG_CHIPS_IN_USE   = 3'd0,
        CFG_MISS_LIMIT     = 3'd1,
        CFG_WRAP_LIMIT     = 3'd2,
        CFG_GIVEUP_LIMIT   = 3'd3,
        CFG_RESTART_ENABLE = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [3:0]  chips_in_use;
        logic [2:0]  miss_limit;
        logic [31:0] wrap_limit;
        logic [15:0] giveup_limit;
        logic        restart_enable;
    } cfg_t;

    typedef struct packed {
        logic [3:0]  chip_index;
        logic [31:0] submit_count;
        logic        chips_ready;
    } sample_t;

    typedef struct packed {
        logic        clear_counters;
        logic        reset_chips;
        logic        give_up;
        logic [15:0] reset_total;
    } result_t;

endpackage

// ===== hw/rtl/mcsw_core.sv =====
module mcsw_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  mcsw_pkg::sample_t sample,
    input  mcsw_pkg::cfg_t    cfg,
    output mcsw_pkg::result_t result
);

    logic [31:0] last_count_reg  [mcsw_pkg::MAX_CHIPS];
    logic [31:0] last_count_next [mcsw_pkg::MAX_CHIPS];
    logic [2:0]  miss_count_reg  [mcsw_pkg::MAX_CHIPS];
    logic [2:0]  miss_count_next [mcsw_pkg::MAX_CHIPS];
    logic        fail_pending_reg;
    logic        fail_pending_next;
    logic        scan_skipped_reg;
    logic        scan_skipped_next;
    logic [15:0] resets_done_reg;
    logic [15:0] resets_done_next;

    logic [31:0] n_active;
    logic [31:0] c_wide;
    logic [mcsw_pkg::IDX_W-1:0] idx;
    logic [31:0] last_sel;
    logic [2:0]  miss_inc;
    logic        skip;
    logic        fail;
    logic        give_up;

    always_comb
    begin
        n_active = (32'(cfg.chips_in_use) > 32'(mcsw_pkg::MAX_CHIPS))
                   ? 32'(mcsw_pkg::MAX_CHIPS) : 32'(cfg.chips_in_use);
        c_wide   = 32'(sample.chip_index);
        idx      = mcsw_pkg::IDX_W'(sample.chip_index);
        last_sel = 32'd0;
        miss_inc = 3'd0;
        skip     = scan_skipped_reg;
        fail     = fail_pending_reg;
        give_up  = (sample.chip_index == 4'd0) && cfg.restart_enable
                   && (resets_done_reg > cfg.giveup_limit);

        last_count_next   = last_count_reg;
        miss_count_next   = miss_count_reg;
        fail_pending_next = fail_pending_reg;
        scan_skipped_next = scan_skipped_reg;
        resets_done_next  = resets_done_reg;

        result                = '0;
        result.reset_total    = resets_done_reg;

        if (give_up)
        begin
            result.give_up = 1'b1;
        end
        else if (c_wide < n_active)
        begin
            last_sel = last_count_reg[idx];
            if (sample.chip_index == 4'd0)
            begin
                skip = 1'b0;
            end
            scan_skipped_next = skip;
            if (sample.chips_ready && !skip)
            begin
                if (last_sel < sample.submit_count)
                begin
                    if (sample.submit_count > cfg.wrap_limit)
                    begin
                        for (int i = 0; i < mcsw_pkg::MAX_CHIPS; i++)
                        begin
                            if (32'(i) < n_active)
                            begin
                                last_count_next[i] = 32'd0;
                                miss_count_next[i] = 3'd0;
                            end
                        end
                        result.clear_counters = 1'b1;
                        scan_skipped_next     = 1'b1;
                    end
                    else
                    begin
                        miss_count_next[idx] = 3'd0;
                        last_count_next[idx] = sample.submit_count;
                    end
                end
                else if (last_sel != 32'd0)
                begin
                    miss_inc = (miss_count_reg[idx] < mcsw_pkg::MISS_MAX)
                               ? miss_count_reg[idx] + 3'd1 : miss_count_reg[idx];
                    if (miss_inc >= cfg.miss_limit)
                    begin
                        fail = 1'b1;
                        for (int i = 0; i < mcsw_pkg::MAX_CHIPS; i++)
                        begin
                            if (32'(i) < n_active)
                            begin
                                miss_count_next[i] = 3'd0;
                            end
                        end
                    end
                    else
                    begin
                        miss_count_next[idx] = miss_inc;
                    end
                end
            end
            if ((c_wide == n_active - 32'd1) && fail)
            begin
                result.reset_chips = 1'b1;
                if (resets_done_reg < mcsw_pkg::TOTAL_MAX)
                begin
                    resets_done_next = resets_done_reg + 16'd1;
                end
                fail = 1'b0;
            end
            fail_pending_next  = fail;
            result.reset_total = resets_done_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mcsw_pkg::MAX_CHIPS; i++)
            begin
                last_count_reg[i] <= 32'd0;
                miss_count_reg[i] <= 3'd0;
            end
            fail_pending_reg <= 1'b0;
            scan_skipped_reg <= 1'b0;
            resets_done_reg  <= 16'd0;
        end
        else if (step)
        begin
            last_count_reg   <= last_count_next;
            miss_count_reg   <= miss_count_next;
            fail_pending_reg <= fail_pending_next;
            scan_skipped_reg <= scan_skipped_next;
            resets_done_reg  <= resets_done_next;
        end
    end

endmodule

// ===== hw/rtl/multi_channel_stall_watchdog_unit.sv =====
// Channel  | Handshake           | Payload
// ---------+---------------------+-------------------------------------------------
// in       | in_valid/in_ready   | chip_index, submit_count, chips_ready
// out      | out_valid/out_ready | clear_counters, reset_chips, give_up, reset_total
// cfg      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One item per cycle sustained while the output is not stalled; an accepted item
// is held in the input register and its result in the output register until it leaves.
// The watchdog state is updated in the same cycle the result is registered.
// rst_n clears the watchdog counts and flags and the valid bits, and loads the default register values.
// A stalled output holds the result; the input register takes one more item,
// then in_ready drops until the result leaves.
module multi_channel_stall_watchdog_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  chip_index,
    input  logic [31:0] submit_count,
    input  logic        chips_ready,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        clear_counters,
    output logic        reset_chips,
    output logic        give_up,
    output logic [15:0] reset_total,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    mcsw_pkg::cfg_t    cfg_reg;
    mcsw_pkg::sample_t sample_reg;
    logic              sample_valid_reg;
    mcsw_pkg::result_t result_reg;
    mcsw_pkg::result_t result_next;
    logic              out_valid_reg;
    logic              out_free;
    logic              step;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;
    assign step      = sample_valid_reg && out_free;
    assign in_ready  = !sample_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.chips_in_use   <= mcsw_pkg::CHIPS_IN_USE_RST;
            cfg_reg.miss_limit     <= mcsw_pkg::MISS_LIMIT_RST;
            cfg_reg.wrap_limit     <= mcsw_pkg::WRAP_LIMIT_RST;
            cfg_reg.giveup_limit   <= mcsw_pkg::GIVEUP_LIMIT_RST;
            cfg_reg.restart_enable <= mcsw_pkg::RESTART_ENABLE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mcsw_pkg::CFG_CHIPS_IN_USE:   cfg_reg.chips_in_use   <= cfg_data[3:0];
                mcsw_pkg::CFG_MISS_LIMIT:     cfg_reg.miss_limit     <= cfg_data[2:0];
                mcsw_pkg::CFG_WRAP_LIMIT:     cfg_reg.wrap_limit     <= cfg_data;
                mcsw_pkg::CFG_GIVEUP_LIMIT:   cfg_reg.giveup_limit   <= cfg_data[15:0];
                mcsw_pkg::CFG_RESTART_ENABLE: cfg_reg.restart_enable <= cfg_data[0];
                default:                      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                sample_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= step;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            sample_reg.chip_index   <= chip_index;
            sample_reg.submit_count <= submit_count;
            sample_reg.chips_ready  <= chips_ready;
        end
        if (step)
        begin
            result_reg <= result_next;
        end
    end

    mcsw_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .sample (sample_reg),
        .cfg    (cfg_reg),
        .result (result_next)
    );

    assign out_valid      = out_valid_reg;
    assign clear_counters = result_reg.clear_counters;
    assign reset_chips    = result_reg.reset_chips;
    assign give_up        = result_reg.give_up;
    assign reset_total    = result_reg.reset_total;

endmodule

// ===== bench/multi_channel_stall_watchdog_unit_test.sv =====
`timescale 1ns / 1ps

module multi_channel_stall_watchdog_unit_test;

    localparam int CYCLE_LIMIT = 1000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [3:0]  chip_index = '0;
    logic [31:0] submit_count = '0;
    logic        chips_ready = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        clear_counters;
    logic        reset_chips;
    logic        give_up;
    logic [15:0] reset_total;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    mcsw_pkg::cfg_t regs;
    logic [31:0] seen_count [mcsw_pkg::MAX_CHIPS] = '{default: '0};
    logic [2:0]  stall_miss [mcsw_pkg::MAX_CHIPS] = '{default: '0};
    logic        failure_armed = 1'b0;
    logic        scan_cut = 1'b0;
    logic [15:0] reset_tally = '0;

    logic [31:0] host_count [mcsw_pkg::MAX_CHIPS] = '{default: '0};
    logic        host_stuck [mcsw_pkg::MAX_CHIPS] = '{default: 1'b0};

    mcsw_pkg::sample_t samples_to_send [$];
    mcsw_pkg::result_t verdicts_due [$];
    mcsw_pkg::sample_t on_wire;
    mcsw_pkg::result_t want;
    logic        steady = 1'b0;
    int          outstanding = 0;
    int          errors = 0;
    int          cycle_count = 0;
    int          items_sent = 0;
    int          reg_writes = 0;
    int          clears_seen = 0;
    int          resets_seen = 0;
    int          giveups_seen = 0;

    multi_channel_stall_watchdog_unit DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .chip_index     (chip_index),
        .submit_count   (submit_count),
        .chips_ready    (chips_ready),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .clear_counters (clear_counters),
        .reset_chips    (reset_chips),
        .give_up        (give_up),
        .reset_total    (reset_total),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int active_chips();
        return (regs.chips_in_use > mcsw_pkg::MAX_CHIPS)
               ? mcsw_pkg::MAX_CHIPS : int'(regs.chips_in_use);
    endfunction

    function automatic mcsw_pkg::result_t watchdog_predict(mcsw_pkg::sample_t s);
        mcsw_pkg::result_t r;
        int      n;
        int      c;
        r = '0;
        n = active_chips();
        c = int'(s.chip_index);
        if (c == 0 && regs.restart_enable && reset_tally > regs.giveup_limit)
        begin
            r.give_up = 1'b1;
            r.reset_total = reset_tally;
            return r;
        end
        if (c < n)
        begin
            if (c == 0)
                scan_cut = 1'b0;
            if (s.chips_ready && !scan_cut)
            begin
                if (seen_count[c] < s.submit_count)
                begin
                    if (s.submit_count > regs.wrap_limit)
                    begin
                        for (int i = 0; i < n; i++)
                        begin
                            seen_count[i] = '0;
                            stall_miss[i] = '0;
                        end
                        r.clear_counters = 1'b1;
                        scan_cut = 1'b1;
                    end
                    else
                    begin
                        stall_miss[c] = '0;
                        seen_count[c] = s.submit_count;
                    end
                end
                else if (seen_count[c] != 0)
                begin
                    if (stall_miss[c] < mcsw_pkg::MISS_MAX)
                        stall_miss[c] = stall_miss[c] + 3'd1;
                    if (stall_miss[c] >= regs.miss_limit)
                    begin
                        failure_armed = 1'b1;
                        for (int i = 0; i < n; i++)
                            stall_miss[i] = '0;
                    end
                end
            end
            if (c == n - 1 && failure_armed)
            begin
                r.reset_chips = 1'b1;
                if (reset_tally < mcsw_pkg::TOTAL_MAX)
                    reset_tally = reset_tally + 16'd1;
                failure_armed = 1'b0;
            end
        end
        r.reset_total = reset_tally;
        return r;
    endfunction

    task automatic match_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t: %s expected %0h, got %0h", $time, name, exp_v, act_v);
        end
    endtask

    task automatic post(input logic [3:0] c, input logic [31:0] cnt, input logic rdy);
        mcsw_pkg::sample_t item;
        item.chip_index = c;
        item.submit_count = cnt;
        item.chips_ready = rdy;
        samples_to_send.push_back(item);
        outstanding++;
        items_sent++;
    endtask

    task automatic write_reg(input mcsw_pkg::cfg_idx_t idx, input logic [31:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            mcsw_pkg::CFG_CHIPS_IN_USE:   regs.chips_in_use = data[3:0];
            mcsw_pkg::CFG_MISS_LIMIT:     regs.miss_limit = data[2:0];
            mcsw_pkg::CFG_WRAP_LIMIT:     regs.wrap_limit = data;
            mcsw_pkg::CFG_GIVEUP_LIMIT:   regs.giveup_limit = data[15:0];
            mcsw_pkg::CFG_RESTART_ENABLE: regs.restart_enable = data[0];
            default: ;
        endcase
        reg_writes++;
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(input logic [3:0] chips, input logic [2:0] misses,
                            input logic [31:0] wrap, input logic [15:0] giveup,
                            input logic restart);
        write_reg(mcsw_pkg::CFG_CHIPS_IN_USE, 32'(chips));
        write_reg(mcsw_pkg::CFG_MISS_LIMIT, 32'(misses));
        write_reg(mcsw_pkg::CFG_WRAP_LIMIT, wrap);
        write_reg(mcsw_pkg::CFG_GIVEUP_LIMIT, 32'(giveup));
        write_reg(mcsw_pkg::CFG_RESTART_ENABLE, 32'(restart));
    endtask

    task automatic settle();
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic queue_scans(input int target);
        int n;
        int pushed;
        int act;
        logic rdy;
        n = active_chips();
        pushed = 0;
        while (pushed < target)
        begin
            if (n == 0)
            begin
                post(4'($urandom_range(15)), $urandom, 1'($urandom_range(1)));
                pushed++;
            end
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(99) < 6)
                begin
                    post(4'($urandom_range(15)), $urandom, 1'($urandom_range(1)));
                    pushed++;
                end
                if (i == 0)
                    for (int j = 0; j < mcsw_pkg::MAX_CHIPS; j++)
                        if ($urandom_range(99) < 15)
                            host_stuck[j] = !host_stuck[j];
                act = $urandom_range(99);
                if (act < 4)
                    host_count[i] = regs.wrap_limit + 32'($urandom_range(1, 1000));
                else if (act < 7)
                    host_count[i] = $urandom_range(0, host_count[i]);
                else if (!host_stuck[i])
                    host_count[i] = host_count[i] + 32'($urandom_range(1, 300));
                rdy = ($urandom_range(99) >= 5);
                post(4'(i), host_count[i], rdy);
                pushed++;
                if (rdy && host_count[i] > regs.wrap_limit)
                    for (int j = 0; j < mcsw_pkg::MAX_CHIPS; j++)
                        host_count[j] = '0;
                if ($urandom_range(99) < 4)
                    break;
            end
        end
    endtask

    // Driver: hold the item until accepted, predict on acceptance.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            chip_index <= '0;
            submit_count <= '0;
            chips_ready <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                verdicts_due.push_back(watchdog_predict(on_wire));
            if (!in_valid || in_ready)
            begin
                if (samples_to_send.size() != 0 && (steady || $urandom_range(99) >= 27))
                begin
                    on_wire = samples_to_send.pop_front();
                    in_valid <= 1'b1;
                    chip_index <= on_wire.chip_index;
                    submit_count <= on_wire.submit_count;
                    chips_ready <= on_wire.chips_ready;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (verdicts_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with no item pending: clear %b reset %b give_up %b total %0d",
                             $time, clear_counters, reset_chips, give_up, reset_total);
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    outstanding--;
                    match_field("clear_counters", 16'(want.clear_counters), 16'(clear_counters));
                    match_field("reset_chips", 16'(want.reset_chips), 16'(reset_chips));
                    match_field("give_up", 16'(want.give_up), 16'(give_up));
                    match_field("reset_total", want.reset_total, reset_total);
                    clears_seen += int'(want.clear_counters);
                    resets_seen += int'(want.reset_chips);
                    giveups_seen += int'(want.give_up);
                end
            end
            out_ready <= steady || ($urandom_range(99) >= 27);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        regs.chips_in_use = mcsw_pkg::CHIPS_IN_USE_RST;
        regs.miss_limit = mcsw_pkg::MISS_LIMIT_RST;
        regs.wrap_limit = mcsw_pkg::WRAP_LIMIT_RST;
        regs.giveup_limit = mcsw_pkg::GIVEUP_LIMIT_RST;
        regs.restart_enable = mcsw_pkg::RESTART_ENABLE_RST;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults: one chip, five misses
        post(4'd0, 32'd0, 1'b1);
        post(4'd0, 32'hFFFF_FFFF, 1'b0);
        post(4'd5, 32'd100, 1'b1);
        post(4'd15, 32'd100, 1'b1);
        post(4'd0, 32'd100, 1'b1);
        repeat (5) post(4'd0, 32'd100, 1'b1);
        post(4'd0, 32'd5000001, 1'b1);
        settle();

        // wrap on any rise, then skip the rest of the scan
        set_regs(4'd12, 3'd7, 32'd0, 16'd65535, 1'b1);
        post(4'd0, 32'd1, 1'b1);
        post(4'd1, 32'd9, 1'b1);
        post(4'd11, 32'd9, 1'b0);
        post(4'd0, 32'hFFFF_FFFF, 1'b1);
        settle();

        // no chips in use; give-up still wins on index 0
        set_regs(4'd0, 3'd0, 32'hFFFF_FFFF, 16'd0, 1'b1);
        post(4'd0, 32'd7, 1'b1);
        post(4'd3, 32'd7, 1'b1);
        settle();

        // more chips than exist, any miss fails
        set_regs(4'd15, 3'd0, 32'hFFFF_FFFF, 16'd0, 1'b0);
        post(4'd0, 32'd20, 1'b1);
        post(4'd11, 32'd0, 1'b1);
        post(4'd0, 32'd20, 1'b1);
        post(4'd11, 32'd0, 1'b1);
        settle();

        for (int p = 0; p < 8; p++)
        begin
            logic [31:0] wrap;
            case ($urandom_range(3))
                0: wrap = 32'hFFFF_FFFF;
                1: wrap = mcsw_pkg::WRAP_LIMIT_RST;
                2: wrap = $urandom_range(400, 4000);
                default: wrap = $urandom;
            endcase
            set_regs(4'($urandom_range(1, 15)), 3'($urandom_range(7)), wrap,
                     $urandom_range(1) ? 16'($urandom_range(6)) : 16'($urandom_range(65535)),
                     1'($urandom_range(1)));
            steady = (p == 3);
            if (p == 5)
            begin
                queue_scans(25);
                settle();
                queue_scans(25);
            end
            else
                queue_scans(50);
            settle();
        end
        steady = 1'b0;

        if (verdicts_due.size() != 0)
        begin
            errors++;
            $display("%0t: %0d predicted results never arrived", $time, verdicts_due.size());
        end
        $display("Sent %0d samples over %0d register writes in %0d cycles.",
                 items_sent, reg_writes, cycle_count);
        $display("Saw %0d counter clears, %0d chip resets, %0d give-ups; %0d mismatches.",
                 clears_seen, resets_seen, giveups_seen, errors);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/mcsw_pkg.sv
hw/rtl/mcsw_core.sv
hw/rtl/multi_channel_stall_watchdog_unit.sv
bench/multi_channel_stall_watchdog_unit_test.sv
